FILE: src/srbdc_pkg.sv
// Shared types and constants for the shadow register bank with delayed commit.
package srbdc_pkg;

	localparam int unsigned MODE_W     = 2;
	localparam int unsigned TAG_W      = 8;
	localparam int unsigned ADDR_W     = 6;
	localparam int unsigned MASK_W     = 8;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned DATA_W     = MASK_W * BYTE_W;
	localparam int unsigned CFG_W      = 8;
	localparam int unsigned APB_AW     = 3;
	localparam int unsigned APB_DW     = 32;
	localparam int unsigned CMDQ_PW    = 1;
	localparam int unsigned CMDQ_DEPTH = 2 ** CMDQ_PW;

	typedef enum logic [MODE_W-1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_RETRY = 2'd3
	} op_t;

	typedef enum logic {
		REG_READ_LATENCY     = 1'b0,
		REG_WRITE_VISIBILITY = 1'b1
	} reg_idx_t;

	typedef struct packed {
		op_t                op;
		logic [TAG_W-1:0]   tag;
		logic [ADDR_W-1:0]  addr;
		logic [DATA_W-1:0]  bit_mask;
		logic [DATA_W-1:0]  wdata;
		logic               needs;
		logic               accepts;
	} cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0] read_latency;
		logic [CFG_W-1:0] write_visibility;
	} cfg_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic              is_write;
		logic [DATA_W-1:0] data;
	} qent_t;

	localparam int unsigned QENT_W = $bits(qent_t);

endpackage

FILE: src/srbdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srbdc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/srbdc_front.sv
// Front end: accepts items, decodes them into commands and buffers them for the back end.
module srbdc_front #(
	parameter int unsigned BANK_WORDS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [srbdc_pkg::MODE_W-1:0]     mode,
	input  logic [srbdc_pkg::TAG_W-1:0]      tag,
	input  logic [srbdc_pkg::ADDR_W-1:0]     word_addr,
	input  logic [srbdc_pkg::MASK_W-1:0]     byte_mask,
	input  logic [srbdc_pkg::DATA_W-1:0]     write_data,
	input  logic                             needs_response,
	input  logic                             sink_accepts,
	input  srbdc_pkg::back_ctl_t             back_ctl,
	output logic                             busy,
	output logic                             cmd_valid,
	output srbdc_pkg::cmd_t                  cmd
);
	import srbdc_pkg::*;

	localparam int unsigned ADDR_SPAN = 2 ** ADDR_W;

	logic [ADDR_W-1:0]  addr_wrap [ADDR_SPAN];
	cmd_t               new_cmd;
	cmd_t               fifo_q [CMDQ_DEPTH];
	logic [CMDQ_PW-1:0] wr_ptr_q;
	logic [CMDQ_PW-1:0] rd_ptr_q;
	logic [CMDQ_PW:0]   fill_q;
	logic               accept;

	// wrap table: word address modulo the bank size
	for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_wrap
		assign addr_wrap[g] = ADDR_W'(g % BANK_WORDS);
	end

	// decode the incoming transaction
	always_comb begin
		new_cmd.op      = op_t'(mode);
		new_cmd.tag     = tag;
		new_cmd.addr    = addr_wrap[word_addr];
		new_cmd.wdata   = write_data;
		new_cmd.needs   = needs_response;
		new_cmd.accepts = sink_accepts;
		for (int i = 0; i < MASK_W; i++) begin
			new_cmd.bit_mask[i*BYTE_W +: BYTE_W] = {BYTE_W{byte_mask[i]}};
		end
	end

	assign busy      = (fill_q == (CMDQ_PW+1)'(CMDQ_DEPTH)) || back_ctl.clearing;
	assign accept    = start && !busy;
	assign cmd_valid = (fill_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	// hold decoded commands
	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (back_ctl.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !back_ctl.pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!accept && back_ctl.pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/srbdc_back.sv
// Back end: bank copies, commit countdown and copy sweep, response queue and result drive.
module srbdc_back #(
	parameter int unsigned BANK_WORDS  = 64,
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srbdc_pkg::cfg_t               cfg,
	input  logic                          cmd_valid,
	input  srbdc_pkg::cmd_t               cmd,
	output srbdc_pkg::back_ctl_t          back_ctl,
	output logic                          strobe,
	output logic                          status,
	output logic [srbdc_pkg::TAG_W-1:0]   resp_tag,
	output logic                          resp_is_write,
	output logic [srbdc_pkg::DATA_W-1:0]  read_data,
	output logic                          last
);
	import srbdc_pkg::*;

	localparam int unsigned AW  = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;
	localparam int unsigned SW  = $clog2(BANK_WORDS + 1);
	localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_RD     = 7'b0000100,
		S_WR     = 7'b0001000,
		S_COMMIT = 7'b0010000,
		S_SVC    = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [SW-1:0]      sweep_q;
	logic               copy_vld_s1;
	logic [AW-1:0]      copy_addr_s1;
	logic               commit_pending_q;
	logic [CFG_W-1:0]   commit_cd_q;
	logic [CFG_W-1:0]   qcd_q [QUEUE_DEPTH];
	logic [QAW-1:0]     head_q;
	logic [CW-1:0]      count_q;
	logic               retry_wait_q;
	logic               strobe_q;
	logic               status_q;
	logic [TAG_W-1:0]   tag_q;
	logic               is_write_q;
	logic [DATA_W-1:0]  data_q;
	logic               last_q;

	logic               sh_we, sh_re, cm_we, cm_re, qm_we, qm_re;
	logic [AW-1:0]      sh_waddr, sh_raddr, cm_waddr, cm_raddr;
	logic [DATA_W-1:0]  sh_wdata, sh_rdata, cm_wdata, cm_rdata;
	logic [QAW-1:0]     qm_waddr, qm_raddr;
	logic [QENT_W-1:0]  qm_wdata, qm_rdata;

	logic [AW-1:0]      in_addr, cur_addr;
	logic               dispatch, drop, tick_step, push, copy_rd;
	logic               q_full, q_empty, head_ready, last_emit;
	logic [QAW-1:0]     head_nxt, tail;
	logic [CW:0]        tail_sum;
	logic [CFG_W-1:0]   vis, commit_cd_dec, push_cd;
	logic [DATA_W-1:0]  merged;
	qent_t              push_ent, q_head;

	// bank copies and response payload store
	srbdc_ram #(.WIDTH(DATA_W), .DEPTH(BANK_WORDS)) u_shadow (
		.clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
		.re(sh_re), .raddr(sh_raddr), .rdata(sh_rdata)
	);

	srbdc_ram #(.WIDTH(DATA_W), .DEPTH(BANK_WORDS)) u_committed (
		.clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
		.re(cm_re), .raddr(cm_raddr), .rdata(cm_rdata)
	);

	srbdc_ram #(.WIDTH(QENT_W), .DEPTH(QUEUE_DEPTH)) u_rspq (
		.clk(clk), .we(qm_we), .waddr(qm_waddr), .wdata(qm_wdata),
		.re(qm_re), .raddr(qm_raddr), .rdata(qm_rdata)
	);

	// classify the command at the head of the front queue
	assign in_addr   = AW'(cmd.addr);
	assign cur_addr  = AW'(cmd_q.addr);
	assign dispatch  = (state_q == S_IDLE) && cmd_valid;
	assign q_full    = (count_q == CW'(QUEUE_DEPTH));
	assign q_empty   = (count_q == '0);
	assign drop      = dispatch && cmd.needs && q_full &&
	                   ((cmd.op == OP_READ) || (cmd.op == OP_WRITE));
	assign tick_step = dispatch && (cmd.op == OP_TICK);
	assign copy_rd   = (state_q == S_COMMIT) && (sweep_q != SW'(BANK_WORDS));

	// queue pointers
	assign head_nxt   = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_sum   = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail       = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
	                    QAW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : QAW'(tail_sum);
	assign head_ready = !retry_wait_q && !q_empty && (qcd_q[head_q] == '0);
	assign last_emit  = (count_q == CW'(1)) || (qcd_q[head_nxt] != '0);

	// commit timing
	assign vis           = (cfg.write_visibility == '0) ? CFG_W'(1) : cfg.write_visibility;
	assign commit_cd_dec = (commit_cd_q != '0) ? commit_cd_q - 1'b1 : commit_cd_q;

	assign merged = (sh_rdata & ~cmd_q.bit_mask) | (cmd_q.wdata & cmd_q.bit_mask);

	// build the entry to enqueue
	always_comb begin
		push_ent = '0;
		push_cd  = '0;
		push     = 1'b0;
		case (state_q)
			S_RD: begin
				push              = 1'b1;
				push_ent.tag      = cmd_q.tag;
				push_ent.is_write = 1'b0;
				push_ent.data     = cm_rdata;
				push_cd           = cfg.read_latency;
			end
			S_WR: begin
				push              = cmd_q.needs;
				push_ent.tag      = cmd_q.tag;
				push_ent.is_write = 1'b1;
				push_ent.data     = '0;
				push_cd           = vis;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assign q_head = qm_rdata;

	// steer the memory ports
	always_comb begin
		sh_we    = 1'b0;
		sh_waddr = cur_addr;
		sh_wdata = merged;
		sh_re    = 1'b0;
		sh_raddr = in_addr;
		cm_we    = 1'b0;
		cm_waddr = copy_addr_s1;
		cm_wdata = sh_rdata;
		cm_re    = 1'b0;
		cm_raddr = in_addr;
		case (state_q)
			S_CLEAR: begin
				sh_we    = 1'b1;
				sh_waddr = AW'(sweep_q);
				sh_wdata = '0;
				cm_we    = 1'b1;
				cm_waddr = AW'(sweep_q);
				cm_wdata = '0;
			end
			S_IDLE: begin
				sh_re = cmd_valid && (cmd.op == OP_WRITE);
				cm_re = cmd_valid && (cmd.op == OP_READ);
			end
			S_WR: begin
				sh_we = 1'b1;
			end
			S_COMMIT: begin
				sh_re    = copy_rd;
				sh_raddr = AW'(sweep_q);
				cm_we    = copy_vld_s1;
			end
			default: begin
				sh_we = 1'b0;
			end
		endcase
	end

	assign qm_we    = push;
	assign qm_waddr = tail;
	assign qm_wdata = push_ent;
	assign qm_re    = (state_q == S_SVC) && head_ready && cmd_q.accepts;
	assign qm_raddr = head_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_CLEAR;
			sweep_q          <= '0;
			copy_vld_s1      <= 1'b0;
			commit_pending_q <= 1'b0;
			commit_cd_q      <= '0;
			head_q           <= '0;
			count_q          <= '0;
			retry_wait_q     <= 1'b0;
			strobe_q         <= 1'b0;
		end else begin
			strobe_q    <= drop || (state_q == S_EMIT);
			copy_vld_s1 <= copy_rd;
			case (state_q)
				S_CLEAR: begin
					if (sweep_q == SW'(BANK_WORDS - 1)) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							OP_TICK: begin
								state_q <= S_SVC;
								if (commit_pending_q) begin
									commit_cd_q <= commit_cd_dec;
									if (commit_cd_dec == '0) begin
										commit_pending_q <= 1'b0;
										state_q          <= S_COMMIT;
									end
								end
							end
							OP_READ: begin
								if (cmd.needs && !q_full) begin
									state_q <= S_RD;
								end
							end
							OP_WRITE: begin
								if (!(cmd.needs && q_full)) begin
									state_q <= S_WR;
								end
							end
							OP_RETRY: begin
								retry_wait_q <= 1'b0;
								state_q      <= S_SVC;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RD: begin
					count_q <= count_q + 1'b1;
					state_q <= (cfg.read_latency == '0) ? S_SVC : S_IDLE;
				end
				S_WR: begin
					if (!commit_pending_q) begin
						commit_pending_q <= 1'b1;
						commit_cd_q      <= vis;
					end
					if (cmd_q.needs) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_COMMIT: begin
					if (sweep_q == SW'(BANK_WORDS)) begin
						sweep_q <= '0;
						state_q <= S_SVC;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_SVC: begin
					state_q <= S_IDLE;
					if (head_ready) begin
						if (cmd_q.accepts) begin
							state_q <= S_EMIT;
						end else begin
							retry_wait_q <= 1'b1;
						end
					end
				end
				S_EMIT: begin
					head_q  <= head_nxt;
					count_q <= count_q - 1'b1;
					state_q <= last_emit ? S_IDLE : S_SVC;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the current command, copy address and result payload
	always_ff @(posedge clk) begin
		if (dispatch) begin
			cmd_q <= cmd;
		end
		if (copy_rd) begin
			copy_addr_s1 <= AW'(sweep_q);
		end
		if (drop) begin
			status_q   <= 1'b1;
			tag_q      <= cmd.tag;
			is_write_q <= (cmd.op == OP_WRITE);
			data_q     <= '0;
			last_q     <= 1'b1;
		end else if (state_q == S_EMIT) begin
			status_q   <= 1'b0;
			tag_q      <= q_head.tag;
			is_write_q <= q_head.is_write;
			data_q     <= q_head.data;
			last_q     <= last_emit;
		end
	end

	// per-entry response countdowns: load on enqueue, step down on ticks
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (push && (tail == QAW'(i))) begin
				qcd_q[i] <= push_cd;
			end else if (tick_step && (qcd_q[i] != '0)) begin
				qcd_q[i] <= qcd_q[i] - 1'b1;
			end
		end
	end

	assign back_ctl.pop      = dispatch;
	assign back_ctl.clearing = (state_q == S_CLEAR);

	assign strobe        = strobe_q;
	assign status        = status_q;
	assign resp_tag      = tag_q;
	assign resp_is_write = is_write_q;
	assign read_data     = data_q;
	assign last          = last_q;

endmodule

FILE: src/shadow_register_bank_delayed_commit_unit.sv
// Top level: configuration registers, front end and back end of the shadow register bank.
//
// Usage: after reset the block clears both bank copies, one word per cycle, and holds busy
// high until the clear is done. Items are taken on start while busy is low and wait in a
// two-entry command queue; busy then rises only while that queue is full. The back end
// runs items one at a time: a dropped request or a read without response ends in the idle
// state, a write passes through the write state, a tick or a retry through the service
// state, and a read through the read state and, with zero latency, the service state too.
// Queued results leave on the strobe through the service and emit states, one per emit.
// Each result is one cycle wide and cannot be held off. A tick that expires the commit
// countdown also runs the shadow-to-committed copy sweep, bounded by the one read port of
// the shadow RAM. The user must write configuration over APB only while the block is idle;
// the block itself does not enforce this.
module shadow_register_bank_delayed_commit_unit #(
	parameter int unsigned BANK_WORDS  = 64,
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [srbdc_pkg::APB_AW-1:0]  paddr,
	input  logic [srbdc_pkg::APB_DW-1:0]  pwdata,
	output logic [srbdc_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [srbdc_pkg::MODE_W-1:0]  mode,
	input  logic [srbdc_pkg::TAG_W-1:0]   tag,
	input  logic [srbdc_pkg::ADDR_W-1:0]  word_addr,
	input  logic [srbdc_pkg::MASK_W-1:0]  byte_mask,
	input  logic [srbdc_pkg::DATA_W-1:0]  write_data,
	input  logic                          needs_response,
	input  logic                          sink_accepts,
	output logic                          strobe,
	output logic                          status,
	output logic [srbdc_pkg::TAG_W-1:0]   resp_tag,
	output logic                          resp_is_write,
	output logic [srbdc_pkg::DATA_W-1:0]  read_data,
	output logic                          last
);
	import srbdc_pkg::*;

	logic [CFG_W-1:0] read_latency_q;
	logic [CFG_W-1:0] write_visibility_q;
	logic             cfg_wr;
	reg_idx_t         reg_idx;
	cfg_t             cfg;
	back_ctl_t        back_ctl;
	logic             cmd_valid;
	cmd_t             cmd;

	// configuration register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_latency_q     <= '0;
			write_visibility_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_READ_LATENCY:     read_latency_q     <= pwdata[CFG_W-1:0];
				REG_WRITE_VISIBILITY: write_visibility_q <= pwdata[CFG_W-1:0];
				default:              read_latency_q     <= read_latency_q;
			endcase
		end
	end

	// readback
	always_comb begin
		case (reg_idx)
			REG_READ_LATENCY:     prdata = APB_DW'(read_latency_q);
			REG_WRITE_VISIBILITY: prdata = APB_DW'(write_visibility_q);
			default:              prdata = '0;
		endcase
	end

	assign cfg.read_latency     = read_latency_q;
	assign cfg.write_visibility = write_visibility_q;

	srbdc_front #(.BANK_WORDS(BANK_WORDS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.mode(mode),
		.tag(tag),
		.word_addr(word_addr),
		.byte_mask(byte_mask),
		.write_data(write_data),
		.needs_response(needs_response),
		.sink_accepts(sink_accepts),
		.back_ctl(back_ctl),
		.busy(busy),
		.cmd_valid(cmd_valid),
		.cmd(cmd)
	);

	srbdc_back #(.BANK_WORDS(BANK_WORDS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.back_ctl(back_ctl),
		.strobe(strobe),
		.status(status),
		.resp_tag(resp_tag),
		.resp_is_write(resp_is_write),
		.read_data(read_data),
		.last(last)
	);

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the shadow register bank with delayed commit.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import srbdc_pkg::*;

	localparam int BANK         = 64;
	localparam int QDEPTH       = 16;
	localparam int SETTLE       = 300;
	localparam int QUIET_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 220;

	typedef struct {
		op_t               op;
		logic [TAG_W-1:0]  tag;
		logic [ADDR_W-1:0] addr;
		logic [MASK_W-1:0] mask;
		logic [DATA_W-1:0] wdata;
		logic              needs;
		logic              accepts;
	} access_t;

	typedef struct {
		logic              status;
		logic [TAG_W-1:0]  tag;
		logic              is_write;
		logic [DATA_W-1:0] data;
		logic              last;
	} resp_t;

	logic                clk;
	logic                arst_n         = 1'b0;
	logic                psel           = 1'b0;
	logic                penable        = 1'b0;
	logic                pwrite         = 1'b0;
	logic [APB_AW-1:0]   paddr          = '0;
	logic [APB_DW-1:0]   pwdata         = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                start          = 1'b0;
	logic                busy;
	logic [MODE_W-1:0]   mode           = OP_TICK;
	logic [TAG_W-1:0]    tag            = '0;
	logic [ADDR_W-1:0]   word_addr      = '0;
	logic [MASK_W-1:0]   byte_mask      = '0;
	logic [DATA_W-1:0]   write_data     = '0;
	logic                needs_response = 1'b0;
	logic                sink_accepts   = 1'b0;
	logic                strobe;
	logic                status;
	logic [TAG_W-1:0]    resp_tag;
	logic                resp_is_write;
	logic [DATA_W-1:0]   read_data;
	logic                last;

	// Bank model: committed and shadow copies, commit timer, response queue
	logic [DATA_W-1:0] live_words [BANK];
	logic [DATA_W-1:0] staged_words [BANK];
	logic              commit_armed = 1'b0;
	logic [CFG_W-1:0]  commit_left  = '0;
	logic [TAG_W-1:0]  rq_tag [QDEPTH];
	logic              rq_wr [QDEPTH];
	logic [DATA_W-1:0] rq_data [QDEPTH];
	logic [CFG_W-1:0]  rq_left [QDEPTH];
	int                rq_head  = 0;
	int                rq_count = 0;
	logic              retry_hold = 1'b0;
	logic [CFG_W-1:0]  cfg_latency    = '0;
	logic [CFG_W-1:0]  cfg_visibility = '0;

	resp_t item_results[$];
	resp_t awaited_responses[$];
	int    fail_count   = 0;
	int    items_sent   = 0;
	int    idle_pct     = 0;
	int    quiet_cycles = 0;

	shadow_register_bank_delayed_commit_unit #(
		.BANK_WORDS(BANK),
		.QUEUE_DEPTH(QDEPTH)
	) uut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Clear the bank model at time zero, as the block does after reset
	initial begin
		foreach (live_words[i]) begin
			live_words[i]   = '0;
			staged_words[i] = '0;
		end
	end

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void queue_response(logic [TAG_W-1:0] t, logic wr,
			logic [DATA_W-1:0] d, logic [CFG_W-1:0] left);
		int slot;
		slot = (rq_head + rq_count) % QDEPTH;
		rq_tag[slot]  = t;
		rq_wr[slot]   = wr;
		rq_data[slot] = d;
		rq_left[slot] = left;
		rq_count++;
	endfunction

	// Send due head entries in order; a refusal blocks the queue until a retry
	function automatic void release_due(logic accepts);
		if (retry_hold)
			return;
		while (rq_count > 0 && rq_left[rq_head] == 0) begin
			if (!accepts) begin
				retry_hold = 1'b1;
				return;
			end
			item_results.push_back('{1'b0, rq_tag[rq_head], rq_wr[rq_head],
				rq_data[rq_head], 1'b0});
			rq_head = (rq_head + 1) % QDEPTH;
			rq_count--;
		end
	endfunction

	// Advance the bank model by one transaction and record the results it causes
	function automatic void predict_bank_access(access_t a);
		int                s;
		int                b;
		logic [CFG_W-1:0]  vis;
		logic [DATA_W-1:0] snap;
		vis = (cfg_visibility == 0) ? CFG_W'(1) : cfg_visibility;
		item_results.delete();
		case (a.op)
			OP_TICK: begin
				if (commit_armed) begin
					if (commit_left > 0)
						commit_left--;
					if (commit_left == 0) begin
						live_words   = staged_words;
						commit_armed = 1'b0;
					end
				end
				for (s = 0; s < rq_count; s++) begin
					if (rq_left[(rq_head + s) % QDEPTH] > 0)
						rq_left[(rq_head + s) % QDEPTH]--;
				end
				release_due(a.accepts);
			end
			OP_READ: begin
				snap = live_words[a.addr];
				if (a.needs) begin
					if (rq_count >= QDEPTH) begin
						item_results.push_back('{1'b1, a.tag, 1'b0, {DATA_W{1'b0}}, 1'b0});
					end else begin
						queue_response(a.tag, 1'b0, snap, cfg_latency);
						if (cfg_latency == 0)
							release_due(a.accepts);
					end
				end
			end
			OP_WRITE: begin
				if (a.needs && rq_count >= QDEPTH) begin
					item_results.push_back('{1'b1, a.tag, 1'b1, {DATA_W{1'b0}}, 1'b0});
				end else begin
					for (b = 0; b < MASK_W; b++) begin
						if (a.mask[b])
							staged_words[a.addr][BYTE_W*b +: BYTE_W] = a.wdata[BYTE_W*b +: BYTE_W];
					end
					if (!commit_armed) begin
						commit_armed = 1'b1;
						commit_left  = vis;
					end
					if (a.needs)
						queue_response(a.tag, 1'b1, {DATA_W{1'b0}}, vis);
				end
			end
			default: begin
				retry_hold = 1'b0;
				release_due(a.accepts);
			end
		endcase
		if (item_results.size() > 0)
			item_results[item_results.size()-1].last = 1'b1;
		foreach (item_results[i])
			awaited_responses.push_back(item_results[i]);
	endfunction

	function automatic access_t make_access(op_t op, logic [TAG_W-1:0] t,
			logic [ADDR_W-1:0] ad, logic [MASK_W-1:0] m, logic [DATA_W-1:0] d,
			logic nr, logic sa);
		access_t a;
		a.op      = op;
		a.tag     = t;
		a.addr    = ad;
		a.mask    = m;
		a.wdata   = d;
		a.needs   = nr;
		a.accepts = sa;
		return a;
	endfunction

	// Random fields; addresses lean toward a few words so reads hit written data
	function automatic access_t random_access(op_t op);
		access_t a;
		a.op    = op;
		a.tag   = TAG_W'($urandom);
		a.addr  = ($urandom_range(0, 1) == 0) ? ADDR_W'($urandom_range(0, 7))
			: ADDR_W'($urandom);
		case ($urandom_range(0, 3))
			0:       a.mask = '0;
			1:       a.mask = '1;
			default: a.mask = MASK_W'($urandom);
		endcase
		a.wdata   = ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom};
		a.needs   = ($urandom_range(0, 9) != 0);
		a.accepts = ($urandom_range(0, 11) != 0);
		return a;
	endfunction

	// Drive one transaction after a random gap and hold it until accepted
	task automatic send_access(access_t a);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		mode           <= a.op;
		tag            <= a.tag;
		word_addr      <= a.addr;
		byte_mask      <= a.mask;
		write_data     <= a.wdata;
		needs_response <= a.needs;
		sink_accepts   <= a.accepts;
		do @(posedge clk); while (busy);
		predict_bank_access(a);
		items_sent++;
	endtask

	// Tick until no response, commit or retry is left, then let the block settle
	task automatic quiesce();
		access_t a;
		while (rq_count > 0 || commit_armed || retry_hold) begin
			a = random_access(retry_hold ? OP_RETRY : OP_TICK);
			a.accepts = 1'b1;
			send_access(a);
		end
		start <= 1'b0;
		while (awaited_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write a register, then read it back in the following transfer
	task automatic program_register(reg_idx_t idx, logic [CFG_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_READ_LATENCY)
			cfg_latency = val;
		else
			cfg_visibility = val;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", APB_DW'(val), prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_registers();
		program_register(REG_READ_LATENCY, 8'hFF);
		program_register(REG_WRITE_VISIBILITY, 8'hFF);
		program_register(REG_READ_LATENCY, 8'h00);
		program_register(REG_WRITE_VISIBILITY, 8'h00);
	endtask

	// Commit on the first tick, immediate reads, empty mask, no-response accesses
	task automatic test_commit_and_immediate_read();
		send_access(make_access(OP_WRITE, 8'hFF, 6'd0, 8'hFF, '1, 1'b1, 1'b1));
		send_access(make_access(OP_READ, 8'h00, 6'd0, 8'h00, '0, 1'b1, 1'b1));
		send_access(make_access(OP_TICK, 8'h00, 6'd0, 8'h00, '0, 1'b0, 1'b1));
		send_access(make_access(OP_READ, 8'h01, 6'd0, 8'hFF, '1, 1'b1, 1'b1));
		send_access(make_access(OP_WRITE, 8'h5A, 6'd63, 8'h00, '1, 1'b1, 1'b1));
		send_access(make_access(OP_WRITE, 8'h33, 6'd63, 8'hA5,
			64'h0123_4567_89AB_CDEF, 1'b0, 1'b1));
		send_access(make_access(OP_WRITE, 8'hA5, 6'd63, 8'h5A,
			64'hFEDC_BA98_7654_3210, 1'b1, 1'b1));
		send_access(make_access(OP_TICK, 8'hFF, 6'd63, 8'hFF, '1, 1'b1, 1'b1));
		send_access(make_access(OP_READ, 8'h3C, 6'd63, 8'h00, '0, 1'b1, 1'b1));
		send_access(make_access(OP_READ, 8'hC3, 6'd63, 8'h00, '0, 1'b0, 1'b1));
		send_access(make_access(OP_RETRY, 8'h11, 6'd1, 8'h00, '0, 1'b1, 1'b1));
		send_access(make_access(OP_TICK, 8'h22, 6'd2, 8'h00, '0, 1'b1, 1'b0));
		quiesce();
	endtask

	// A refused response blocks everything behind it until a retry arrives
	task automatic test_refused_response();
		send_access(make_access(OP_READ, 8'h40, 6'd0, 8'h00, '0, 1'b1, 1'b0));
		send_access(make_access(OP_READ, 8'h41, 6'd63, 8'h00, '0, 1'b1, 1'b1));
		send_access(make_access(OP_TICK, 8'h42, 6'd0, 8'h00, '0, 1'b0, 1'b1));
		send_access(make_access(OP_RETRY, 8'h43, 6'd0, 8'h00, '0, 1'b0, 1'b0));
		send_access(make_access(OP_RETRY, 8'h44, 6'd0, 8'h00, '0, 1'b0, 1'b1));
		quiesce();
	endtask

	// Fill the queue, then check that further requests needing a response are dropped whole
	task automatic test_queue_full();
		program_register(REG_READ_LATENCY, 8'd2);
		for (int i = 0; i < QDEPTH; i++)
			send_access(make_access(OP_READ, TAG_W'(8'h80 + i), ADDR_W'(i), 8'h00, '0,
				1'b1, 1'b1));
		send_access(make_access(OP_READ, 8'hE0, 6'd0, 8'h00, '0, 1'b1, 1'b1));
		send_access(make_access(OP_WRITE, 8'hE1, 6'd5, 8'hFF, '1, 1'b1, 1'b1));
		send_access(make_access(OP_WRITE, 8'hE2, 6'd6, 8'h0F, 64'h1111_2222_3333_4444,
			1'b0, 1'b1));
		quiesce();
	endtask

	// Largest countdowns for both the commit timer and the read responses
	task automatic test_long_countdowns();
		program_register(REG_READ_LATENCY, 8'hFF);
		program_register(REG_WRITE_VISIBILITY, 8'hFF);
		send_access(make_access(OP_WRITE, 8'h77, 6'd6, 8'hF0, 64'hAAAA_5555_AAAA_5555,
			1'b1, 1'b1));
		send_access(make_access(OP_READ, 8'h78, 6'd6, 8'h00, '0, 1'b1, 1'b1));
		quiesce();
		program_register(REG_READ_LATENCY, 8'h00);
		send_access(make_access(OP_READ, 8'h79, 6'd6, 8'h00, '0, 1'b1, 1'b1));
		quiesce();
	endtask

	// Bursts of requests followed by ticks, with retries and some noise
	task automatic test_random_phase(logic [CFG_W-1:0] lat, logic [CFG_W-1:0] vis,
			int pct, int count);
		int      target;
		int      k;
		access_t a;
		program_register(REG_READ_LATENCY, lat);
		program_register(REG_WRITE_VISIBILITY, vis);
		idle_pct = pct;
		target   = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 80) begin
				k = $urandom_range(1, 18);
				repeat (k)
					send_access(random_access($urandom_range(0, 1) ? OP_READ : OP_WRITE));
				k = $urandom_range(1, 8);
				repeat (k) begin
					send_access(random_access(OP_TICK));
					if (retry_hold && $urandom_range(0, 99) < 60)
						send_access(random_access(OP_RETRY));
				end
			end else begin
				send_access(random_access(op_t'($urandom_range(0, 3))));
			end
		end
		quiesce();
	endtask

	// Check every result against the oldest expectation
	always @(posedge clk) begin : check_results
		resp_t want;
		if (arst_n && strobe === 1'b1) begin
			if (awaited_responses.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tag %h data %h",
					$time, resp_tag, read_data);
				fail_count++;
			end else begin
				want = awaited_responses[0];
				awaited_responses.delete(0);
				check_field("status", want.status, status);
				check_field("resp_tag", want.tag, resp_tag);
				check_field("resp_is_write", want.is_write, resp_is_write);
				check_field("read_data", want.data, read_data);
				check_field("last", want.last, last);
			end
		end
	end

	// Count cycles in which no transaction of any kind completes
	always @(posedge clk) begin
		if ((start && !busy) || strobe === 1'b1 || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("shadow_register_bank_delayed_commit_unit verification failed");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (busy);
		test_registers();
		test_commit_and_immediate_read();
		test_refused_response();
		test_queue_full();
		test_long_countdowns();
		test_random_phase(CFG_W'($urandom_range(1, 3)), CFG_W'($urandom_range(0, 4)), 30,
			RANDOM_ITEMS / 3);
		test_random_phase(8'd0, CFG_W'($urandom_range(1, 6)), 68, RANDOM_ITEMS / 3);
		test_random_phase(CFG_W'($urandom_range(0, 5)), 8'd0, 0, RANDOM_ITEMS / 3);
		if (fail_count == 0)
			$display("shadow_register_bank_delayed_commit_unit verification clean");
		else
			$display("shadow_register_bank_delayed_commit_unit verification failed");
		$finish;
	end

endmodule
